>>> rtl/srdc_pkg.sv
`timescale 1ns / 1ps

package srdc_pkg;

    // Result status codes
    localparam logic [1:0] ST_SUCCESS  = 2'd0;
    localparam logic [1:0] ST_NO_REPLY = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;
    localparam logic [1:0] ST_BAD_CRC  = 2'd3;

    // Register indexes (word address bit 2)
    localparam logic REG_SYNC   = 1'b0;
    localparam logic REG_MASTER = 1'b1;

    // Register reset values
    localparam logic [7:0] SYNC_RESET   = 8'h05;
    localparam logic [7:0] MASTER_RESET = 8'hFF;

    localparam logic [7:0]  CRC_POLY  = 8'h07;
    localparam logic [31:0] FAIL_DATA = 32'hFFFF_FFFF;

    // Byte position of the received CRC within a datagram
    localparam logic [2:0] LAST_POS = 3'd7;

    // Result of one processed transaction
    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [31:0] data;
    } srdc_result_t;

    // CRC-8 update: MSB-first register, data bits fed LSB first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] din);
        logic [7:0] c;
        c = crc;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7] ^ din[k])
            begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> rtl/srdc_frame.sv
`timescale 1ns / 1ps

module srdc_frame
    import srdc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         process,
    input  logic [7:0]   rx_byte,
    input  logic         timeout,
    input  logic [6:0]   expected_reg,
    input  logic [7:0]   sync_value,
    input  logic [7:0]   reply_address,
    output srdc_result_t result
);

    logic [2:0]  pos_reg, pos_next;
    logic [7:0]  crc_reg, crc_next;
    logic        hdr_bad_reg, hdr_bad_next;
    logic [31:0] data_reg, data_next;

    // Datagram decode and result selection
    always_comb
    begin
        pos_next      = pos_reg;
        crc_next      = crc_reg;
        hdr_bad_next  = hdr_bad_reg;
        data_next     = data_reg;
        result.valid  = timeout || (pos_reg == LAST_POS);
        result.status = ST_SUCCESS;
        result.data   = FAIL_DATA;

        if (timeout)
        begin
            // abort frame, back to sync hunt
            result.status = ST_NO_REPLY;
            pos_next      = '0;
            crc_next      = '0;
            hdr_bad_next  = 1'b0;
            data_next     = '0;
        end
        else if (pos_reg == '0)
        begin
            // hunting for sync
            if (rx_byte == sync_value)
            begin
                pos_next     = 3'd1;
                crc_next     = crc8_feed(8'h00, rx_byte);
                hdr_bad_next = 1'b0;
                data_next    = '0;
            end
        end
        else if (pos_reg != LAST_POS)
        begin
            if ((pos_reg == 3'd1) && (rx_byte != reply_address))
            begin
                hdr_bad_next = 1'b1;
            end
            if ((pos_reg == 3'd2) && (rx_byte != {1'b0, expected_reg}))
            begin
                hdr_bad_next = 1'b1;
            end
            if (pos_reg >= 3'd3)
            begin
                data_next = {data_reg[23:0], rx_byte};
            end
            crc_next = crc8_feed(crc_reg, rx_byte);
            pos_next = pos_reg + 3'd1;
        end
        else
        begin
            // CRC byte: header check takes precedence
            if (hdr_bad_reg)
            begin
                result.status = ST_INVALID;
            end
            else if (rx_byte != crc_reg)
            begin
                result.status = ST_BAD_CRC;
            end
            else
            begin
                result.status = ST_SUCCESS;
                result.data   = data_reg;
            end
            pos_next     = '0;
            crc_next     = '0;
            hdr_bad_next = 1'b0;
            data_next    = '0;
        end
    end

    // Frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            crc_reg     <= '0;
            hdr_bad_reg <= 1'b0;
            data_reg    <= '0;
        end
        else if (process)
        begin
            pos_reg     <= pos_next;
            crc_reg     <= crc_next;
            hdr_bad_reg <= hdr_bad_next;
            data_reg    <= data_next;
        end
    end

endmodule

>>> rtl/serial_reply_datagram_checker.sv
`timescale 1ns / 1ps
// A result is registered twice before it is valid on the output: the byte transaction that
// yields it goes to the input register, then the result goes to the output register.
// Throughput: one byte per cycle; the input register stalls only when it holds a
// result-producing byte (timeout or CRC byte) while the output register is full and stalled.
// Reset (rst_n, async, active low) clears the pipeline valids and the frame state (sync hunt),
// and loads sync value = 0x05, reply address = 0xFF.
module serial_reply_datagram_checker
    import srdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        timeout,
    input  logic [6:0]  expected_reg,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [31:0] reg_data,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0]   sync_value_reg;
    logic [7:0]   reply_address_reg;
    logic         in_valid_reg;
    logic [7:0]   rx_byte_reg;
    logic         timeout_reg;
    logic [6:0]   expected_reg_reg;
    logic         out_valid_reg;
    logic [1:0]   status_reg;
    logic [31:0]  reg_data_reg;
    logic         process;
    logic         cfg_write;
    srdc_result_t result;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_value_reg    <= SYNC_RESET;
            reply_address_reg <= MASTER_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_SYNC:   sync_value_reg    <= pwdata[7:0];
                REG_MASTER: reply_address_reg <= pwdata[7:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_SYNC:   prdata = {24'd0, sync_value_reg};
            REG_MASTER: prdata = {24'd0, reply_address_reg};
            default:    prdata = '0;
        endcase
    end

    // Processing enable: a result-producing byte needs room in the output register
    assign process  = in_valid_reg && (!result.valid || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !process;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            rx_byte_reg      <= rx_byte;
            timeout_reg      <= timeout;
            expected_reg_reg <= expected_reg;
        end
    end

    srdc_frame u_frame (
        .clk           (clk),
        .rst_n         (rst_n),
        .process       (process),
        .rx_byte       (rx_byte_reg),
        .timeout       (timeout_reg),
        .expected_reg  (expected_reg_reg),
        .sync_value    (sync_value_reg),
        .reply_address (reply_address_reg),
        .result        (result)
    );

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process && result.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process && result.valid)
        begin
            status_reg   <= result.status;
            reg_data_reg <= result.data;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign reg_data  = reg_data_reg;

endmodule

>>> rtl/srdc_checker.sv
`timescale 1ns / 1ps

module srdc_checker
    import srdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [1:0]  status,
    input logic [31:0] reg_data
);

    // A stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(reg_data))
        else $error("output transaction changed while stalled");

    // Every failure carries all-ones data
    a_fail_data: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_SUCCESS) |-> reg_data == FAIL_DATA)
        else $error("failure status without all-ones data");

    // Input back-pressure only comes from a full, stalled output
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output back-pressure");

endmodule

bind serial_reply_datagram_checker srdc_checker u_srdc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .reg_data  (reg_data)
);

>>> tb/srdc_reply_checker.sv
`timescale 1ns / 1ps

// Watches both data channels and the register port, predicts every reply
// status and compares it against what the block delivers.
module srdc_reply_checker
    import srdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        timeout,
    input  logic [6:0]  expected_reg,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  status,
    input  logic [31:0] reg_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          outstanding,
    output int          errors
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] data;
    } reply_t;

    reply_t      expected_replies[$];

    // Shadow copy of the configuration and the datagram state
    logic [7:0]  sync_reg;
    logic [7:0]  master_reg;
    logic [2:0]  frame_pos;
    logic [7:0]  frame_crc;
    logic        hdr_bad;
    logic [31:0] data_word;
    int          err_cnt;

    // One byte into the CRC-8; data bits enter LSB first
    function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] d);
        logic [7:0] r;
        logic       fb;
        int         i;
        r = crc;
        for (i = 0; i < 8; i++)
        begin
            fb = r[7] ^ d[i];
            r  = {r[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return r;
    endfunction

    task automatic clear_frame_state();
        frame_pos = '0;
        frame_crc = '0;
        hdr_bad   = 1'b0;
        data_word = '0;
    endtask

    // Advance the datagram state by one byte transaction; queue any reply
    task automatic predict_reply(input logic [7:0] b, input logic tmo, input logic [6:0] er);
        reply_t r;
        if (tmo)
        begin
            clear_frame_state();
            r.status = ST_NO_REPLY;
            r.data   = FAIL_DATA;
            expected_replies.push_back(r);
        end
        else if (frame_pos == 3'd0)
        begin
            // hunting: only the sync byte opens a datagram
            if (b == sync_reg)
            begin
                clear_frame_state();
                frame_crc = crc_step(8'h00, b);
                frame_pos = 3'd1;
            end
        end
        else if (frame_pos != LAST_POS)
        begin
            if (frame_pos == 3'd1 && b != master_reg)
                hdr_bad = 1'b1;
            if (frame_pos == 3'd2 && b != {1'b0, er})
                hdr_bad = 1'b1;
            if (frame_pos >= 3'd3)
                data_word = {data_word[23:0], b};
            frame_crc = crc_step(frame_crc, b);
            frame_pos = frame_pos + 3'd1;
        end
        else
        begin
            // CRC byte: header check takes priority over the CRC check
            r.data = FAIL_DATA;
            if (hdr_bad)
                r.status = ST_INVALID;
            else if (b != frame_crc)
                r.status = ST_BAD_CRC;
            else
            begin
                r.status = ST_SUCCESS;
                r.data   = data_word;
            end
            expected_replies.push_back(r);
            clear_frame_state();
        end
    endtask

    task automatic check_reply();
        reply_t e;
        if (expected_replies.size() == 0)
        begin
            $error("unexpected reply: status %0d reg_data %h", status, reg_data);
            err_cnt++;
        end
        else
        begin
            e = expected_replies.pop_front();
            if (status !== e.status)
            begin
                $error("status mismatch: expected %0d, actual %0d", e.status, status);
                err_cnt++;
            end
            if (reg_data !== e.data)
            begin
                $error("reg_data mismatch: expected %h, actual %h", e.data, reg_data);
                err_cnt++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg   = SYNC_RESET;
            master_reg = MASTER_RESET;
            clear_frame_state();
            expected_replies.delete();
            err_cnt     = 0;
            outstanding <= 0;
            errors      <= 0;
        end
        else
        begin
            // register writes land on the access phase
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[2])
                    REG_SYNC:   sync_reg   = pwdata[7:0];
                    REG_MASTER: master_reg = pwdata[7:0];
                endcase
            end
            // a reply leaving now always belongs to an earlier byte
            if (out_valid && !out_stall)
                check_reply();
            if (in_valid && !in_stall)
                predict_reply(rx_byte, timeout, expected_reg);
            outstanding <= expected_replies.size();
            errors      <= err_cnt;
        end
    end

endmodule

>>> tb/serial_reply_datagram_checker_tb.sv
`timescale 1ns / 1ps

module serial_reply_datagram_checker_tb;
    import srdc_pkg::*;

    localparam int PHASE_ITEMS   = 170;
    localparam int HOLD_CYCLES   = 300;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  rx_byte;
    logic        timeout;
    logic [6:0]  expected_reg;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  status;
    logic [31:0] reg_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int          outstanding;
    int          errors;
    int          idle_cycles;

    logic [7:0]  cur_sync;
    logic [7:0]  cur_master;
    logic        no_gaps;
    logic        hold_req;
    logic        hold_taken;
    logic [7:0]  frame_bytes [0:7];

    serial_reply_datagram_checker i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .timeout      (timeout),
        .expected_reg (expected_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .reg_data     (reg_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    srdc_reply_checker i_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .timeout      (timeout),
        .expected_reg (expected_reg),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .reg_data     (reg_data),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .outstanding  (outstanding),
        .errors       (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog: abort when nothing moves on any port for too long
    always @(posedge clk)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((in_valid && !in_stall) || (out_valid && !out_stall)
                 || (psel && penable && pwrite && pready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // Result side backpressure: random stall runs, plus one long hold on request
    initial
    begin
        int r;
        int n;
        out_stall  = 1'b0;
        hold_taken = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_taken)
            begin
                hold_taken = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    out_stall <= 1'b0;
                    n = $urandom_range(1, 8);
                end
                else if (r < 85)
                begin
                    out_stall <= 1'b1;
                    n = $urandom_range(1, 3);
                end
                else if (r < 95)
                begin
                    out_stall <= 1'b0;
                    n = $urandom_range(30, 80);
                end
                else
                begin
                    out_stall <= 1'b1;
                    n = $urandom_range(15, 40);
                end
                repeat (n) @(posedge clk);
            end
        end
    end

    // CRC over bytes 0..6 of the frame being built
    function automatic logic [7:0] frame_crc();
        logic [7:0] c;
        logic       fb;
        int         j;
        int         i;
        c = 8'h00;
        for (j = 0; j < 7; j++)
        begin
            for (i = 0; i < 8; i++)
            begin
                fb = c[7] ^ frame_bytes[j][i];
                c  = {c[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
            end
        end
        return c;
    endfunction

    // One byte transaction; returns once it is accepted and any random gap after it has passed
    task automatic send_item(input logic [7:0] b, input logic tmo, input logic [6:0] er);
        int r;
        int gap;
        in_valid     <= 1'b1;
        rx_byte      <= b;
        timeout      <= tmo;
        expected_reg <= er;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (no_gaps)
            gap = 0;
        else
        begin
            r   = $urandom_range(0, 99);
            gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Full 8-byte datagram; crc_flip corrupts the CRC byte
    task automatic send_frame(input logic [7:0] addr_byte, input logic [7:0] reg_byte,
                              input logic [31:0] word, input logic [6:0] er,
                              input logic [7:0] crc_flip);
        int i;
        frame_bytes[0] = cur_sync;
        frame_bytes[1] = addr_byte;
        frame_bytes[2] = reg_byte;
        frame_bytes[3] = word[31:24];
        frame_bytes[4] = word[23:16];
        frame_bytes[5] = word[15:8];
        frame_bytes[6] = word[7:0];
        frame_bytes[7] = frame_crc() ^ crc_flip;
        for (i = 0; i < 8; i++)
            send_item(frame_bytes[i], 1'b0, er);
    endtask

    // Stop sending and wait until every reply is in and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] v);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'($urandom), v};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] s, input logic [7:0] m);
        drain();
        write_reg(REG_SYNC, s);
        write_reg(REG_MASTER, m);
        cur_sync   = s;
        cur_master = m;
    endtask

    // Mostly well-formed datagrams with random content, plus timeouts,
    // truncated datagrams and line noise; n counts the bytes sent
    task automatic send_random_sequence(output int n);
        int          r;
        int          k;
        int          i;
        logic [6:0]  er;
        logic [7:0]  a;
        logic [7:0]  g;
        logic [31:0] w;
        logic [7:0]  flip;
        r = $urandom_range(0, 99);
        n = 0;
        er = 7'($urandom);
        if (r < 75)
        begin
            a = cur_master;
            g = {1'b0, er};
            w = $urandom;
            k = $urandom_range(0, 99);
            if (k < 10)
                a = 8'($urandom);
            else if (k < 15)
                g = 8'h80 | 8'($urandom);
            else if (k < 20)
                g = 8'($urandom);
            k = $urandom_range(0, 9);
            if (k == 0)
                w = 32'h0000_0000;
            else if (k == 1)
                w = 32'hFFFF_FFFF;
            flip = ($urandom_range(0, 9) == 0) ? 8'(1 << $urandom_range(0, 7)) : 8'h00;
            send_frame(a, g, w, er, flip);
            n = 8;
        end
        else if (r < 85)
        begin
            send_item(8'($urandom), 1'b1, er);
            n = 1;
        end
        else if (r < 90)
        begin
            // datagram cut short by the reply window expiring
            k = $urandom_range(1, 6);
            send_item(cur_sync, 1'b0, er);
            for (i = 0; i < k; i++)
                send_item(8'($urandom), 1'b0, er);
            send_item(8'($urandom), 1'b1, er);
            n = k + 2;
        end
        else
        begin
            k = $urandom_range(1, 3);
            for (i = 0; i < k; i++)
                send_item(8'($urandom), 1'b0, 7'($urandom));
            n = k;
        end
    endtask

    task automatic run_random(input int target);
        int sent;
        int n;
        sent = 0;
        while (sent < target)
        begin
            send_random_sequence(n);
            sent += n;
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [6:0] er;
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        rx_byte      = '0;
        timeout      = 1'b0;
        expected_reg = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        no_gaps      = 1'b0;
        hold_req     = 1'b0;
        cur_sync     = SYNC_RESET;
        cur_master   = MASTER_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset configuration
        send_item(8'h00, 1'b1, 7'h00);      // timeout while hunting
        send_item(8'hFF, 1'b0, 7'h7F);      // non-sync byte dropped
        send_frame(MASTER_RESET, 8'h7F, 32'hFFFF_FFFF, 7'h7F, 8'h00);
        // register byte above 127 with a bad CRC too: header error wins
        send_frame(MASTER_RESET, 8'h80, 32'h0000_0000, 7'h00, 8'h01);
        // abort mid-datagram; byte ignored on timeout
        send_item(cur_sync, 1'b0, 7'h55);
        send_item(8'h00, 1'b0, 7'h55);
        send_item(8'hFF, 1'b1, 7'h55);

        set_config(8'h00, 8'h00);
        run_random(PHASE_ITEMS);

        set_config(8'hFF, 8'hFF);
        run_random(PHASE_ITEMS);

        // Long receiver hold while the sender keeps pushing back to back
        set_config(8'($urandom), 8'($urandom));
        drain();
        hold_req = 1'b1;
        wait (hold_taken);
        no_gaps = 1'b1;
        repeat (10) send_item(8'($urandom), 1'b1, 7'($urandom));
        repeat (3)
        begin
            er = 7'($urandom);
            send_frame(cur_master, {1'b0, er}, $urandom, er, 8'h00);
        end
        no_gaps = 1'b0;
        run_random(PHASE_ITEMS);

        set_config(8'hA5, 8'h5A);
        run_random(PHASE_ITEMS);

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
